// ===== design/assert_macros.svh =====
// Assertion shorthands. Each expects clk and arst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMP_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_IMP_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/stt_pkg.sv =====
package stt_pkg;

	localparam int KIND_W = 5;
	localparam int LINE_W = 20;
	localparam int COL_W  = 16;
	localparam int OFF_W  = 32;
	localparam int LEN_W  = 16;

	typedef enum logic [KIND_W-1:0] {
		KIND_END    = 5'd0,
		KIND_IDENT  = 5'd1,
		KIND_STRUCT = 5'd2,
		KIND_DEF    = 5'd3,
		KIND_VAL    = 5'd4,
		KIND_MUT    = 5'd5,
		KIND_EXTERN = 5'd6,
		KIND_LBRACE = 5'd7,
		KIND_RBRACE = 5'd8,
		KIND_LPAREN = 5'd9,
		KIND_RPAREN = 5'd10,
		KIND_COLON  = 5'd11,
		KIND_SEMI   = 5'd12,
		KIND_STAR   = 5'd13,
		KIND_COMMA  = 5'd14,
		KIND_EQ     = 5'd15,
		KIND_EQEQ   = 5'd16,
		KIND_ERROR  = 5'd17
	} kind_t;

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_IDENT = 2'd1,
		MODE_EQ    = 2'd2,
		MODE_ERROR = 2'd3
	} mode_t;

	typedef struct packed {
		kind_t             kind;
		logic [LINE_W-1:0] start_line;
		logic [COL_W-1:0]  start_column;
		logic [LINE_W-1:0] end_line;
		logic [COL_W-1:0]  end_column;
		logic [OFF_W-1:0]  start_offset;
		logic [LEN_W-1:0]  length;
		logic              last;
	} tok_t;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_EQ    = 8'h3D;

	function automatic logic is_starter(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic logic is_ident_byte(logic [7:0] c);
		return is_starter(c) || (c >= "0" && c <= "9");
	endfunction

	function automatic kind_t punct_kind(logic [7:0] c);
		kind_t k;
		case (c)
			"{":     k = KIND_LBRACE;
			"}":     k = KIND_RBRACE;
			"(":     k = KIND_LPAREN;
			")":     k = KIND_RPAREN;
			":":     k = KIND_COLON;
			";":     k = KIND_SEMI;
			"*":     k = KIND_STAR;
			",":     k = KIND_COMMA;
			default: k = KIND_ERROR;
		endcase
		return k;
	endfunction

	// word holds the first six kept bytes, first byte in the top octet
	function automatic kind_t kw_kind(logic [LEN_W-1:0] count, logic [47:0] word);
		kind_t k;
		k = KIND_IDENT;
		if (count == LEN_W'(6)) begin
			if (word == "struct") k = KIND_STRUCT;
			else if (word == "extern") k = KIND_EXTERN;
		end else if (count == LEN_W'(3)) begin
			if (word[47:24] == "def") k = KIND_DEF;
			else if (word[47:24] == "val") k = KIND_VAL;
			else if (word[47:24] == "mut") k = KIND_MUT;
		end
		return k;
	endfunction

endpackage

// ===== design/source_text_tokenizer_top.sv =====
// Streaming source tokenizer. Takes one source byte per transfer on the src
// channel and delivers tokens on the tok channel, each with kind, start and end
// line/column, start offset and length; last_of_run marks the final token that a
// byte caused. Outside error mode spaces, tabs and newlines give no token of their
// own, ending any pending one and moving the position; carriage returns only move
// the offset. A byte of zero or end_of_text flushes any pending token, delivers an
// end token and returns the block to its reset state. After an unknown byte every
// further byte but a carriage return gives an error token until the text ends.
// Rate: one byte per cycle sustained while each byte gives at most one token and
// the token side does not stall. A byte is registered at its transfer, classified
// against the lexer state in a single step, and its tokens (none, one or two) are
// written into a four-entry token queue whose head drives the tok channel.
// src_stall rises while the queue, counting the tokens of the byte in flight, would
// hold more than two, since the next byte may add two more; bytes that close one
// token and open another (a token per byte is the most the output side can drain)
// hold the input until the queue has drained back to two.
`include "assert_macros.svh"

module source_text_tokenizer_top #(
	parameter int KEYWORD_PREFIX_BYTES = 7,
	parameter int LINE_BITS            = 20,
	parameter int OFFSET_BITS          = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            src_valid,
	output logic                            src_stall,
	input  logic [7:0]                      char_byte,
	input  logic                            end_of_text,
	output logic                            tok_valid,
	input  logic                            tok_stall,
	output logic [stt_pkg::KIND_W-1:0]      token_kind,
	output logic [stt_pkg::LINE_W-1:0]      start_line,
	output logic [stt_pkg::COL_W-1:0]       start_column,
	output logic [stt_pkg::LINE_W-1:0]      end_line,
	output logic [stt_pkg::COL_W-1:0]       end_column,
	output logic [stt_pkg::OFF_W-1:0]       start_offset,
	output logic [stt_pkg::LEN_W-1:0]       token_length,
	output logic                            last_of_run
);
	import stt_pkg::*;

	localparam int IDX_W = $clog2(KEYWORD_PREFIX_BYTES);
	localparam logic [LEN_W-1:0]       KPB_CNT  = LEN_W'(KEYWORD_PREFIX_BYTES);
	localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
	localparam logic [COL_W-1:0]       COL_ONE  = COL_W'(1);
	localparam logic [OFFSET_BITS-1:0] OFF_ONE  = OFFSET_BITS'(1);
	localparam logic [LEN_W-1:0]       LEN_ONE  = LEN_W'(1);
	localparam int Q_DEPTH = 4;
	localparam int QP_W    = $clog2(Q_DEPTH);
	localparam int QC_W    = QP_W + 1;

	// input register
	logic       in_valid_s1;
	logic [7:0] char_s1;
	logic       eot_s1;

	// lexer state
	mode_t                  mode_q, mode_d;
	logic [7:0]             prefix_q [KEYWORD_PREFIX_BYTES];
	logic [LEN_W-1:0]       count_q, count_d;
	logic [LINE_BITS-1:0]   line_q, line_d;
	logic [COL_W-1:0]       col_q, col_d;
	logic [OFFSET_BITS-1:0] off_q, off_d;
	logic [LINE_BITS-1:0]   tsl_q, tsl_d;
	logic [COL_W-1:0]       tsc_q, tsc_d;
	logic [OFFSET_BITS-1:0] tso_q, tso_d;
	logic [LINE_BITS-1:0]   pl_q, pl_d;
	logic [COL_W-1:0]       pc_q, pc_d;

	logic             pfx_we;
	logic [IDX_W-1:0] pfx_idx;
	logic             consume;
	logic             pending;
	logic             fl_hit, nw_hit;
	logic             is_end_s1;
	tok_t             fl_tok, nw_tok, t0, t1;
	logic [1:0]       n_push;

	// token queue
	tok_t            q_mem [Q_DEPTH];
	logic [QP_W-1:0] wr_q, rd_q;
	logic [QC_W-1:0] cnt_q;
	logic            pop;

	assign src_stall = (cnt_q + QC_W'(n_push)) > QC_W'(Q_DEPTH - 2);
	assign is_end_s1 = in_valid_s1 && (eot_s1 || char_s1 == CH_NUL);
	assign pending   = (mode_q == MODE_IDENT) || (mode_q == MODE_EQ);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else begin
			in_valid_s1 <= src_valid && !src_stall;
		end
	end

	// payload holds unless a new byte transfers
	always_ff @(posedge clk) begin
		if (src_valid && !src_stall) begin
			char_s1 <= char_byte;
			eot_s1  <= end_of_text;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			count_q <= '0;
			line_q  <= LINE_ONE;
			col_q   <= COL_ONE;
			off_q   <= '0;
			tsl_q   <= LINE_ONE;
			tsc_q   <= COL_ONE;
			tso_q   <= '0;
			pl_q    <= LINE_ONE;
			pc_q    <= COL_ONE;
		end else begin
			mode_q  <= mode_d;
			count_q <= count_d;
			line_q  <= line_d;
			col_q   <= col_d;
			off_q   <= off_d;
			tsl_q   <= tsl_d;
			tsc_q   <= tsc_d;
			tso_q   <= tso_d;
			pl_q    <= pl_d;
			pc_q    <= pc_d;
		end
	end

	// keyword prefix: only entries below the identifier count are ever compared
	always_ff @(posedge clk) begin
		if (pfx_we) begin
			prefix_q[pfx_idx] <= char_s1;
		end
	end

	// classify the registered byte against the lexer state
	always_comb begin
		mode_d  = mode_q;
		count_d = count_q;
		line_d  = line_q;
		col_d   = col_q;
		off_d   = off_q;
		tsl_d   = tsl_q;
		tsc_d   = tsc_q;
		tso_d   = tso_q;
		pl_d    = pl_q;
		pc_d    = pc_q;
		pfx_we  = 1'b0;
		pfx_idx = '0;
		consume = 1'b0;
		fl_hit  = 1'b0;
		nw_hit  = 1'b0;

		// pending token as it would be flushed now
		fl_tok.kind         = (mode_q == MODE_EQ) ? KIND_EQ :
			kw_kind(count_q, {prefix_q[0], prefix_q[1], prefix_q[2],
				prefix_q[3], prefix_q[4], prefix_q[5]});
		fl_tok.start_line   = LINE_W'(tsl_q);
		fl_tok.start_column = tsc_q;
		fl_tok.end_line     = LINE_W'(pl_q);
		fl_tok.end_column   = pc_q;
		fl_tok.start_offset = OFF_W'(tso_q);
		fl_tok.length       = (mode_q == MODE_EQ) ? LEN_ONE : count_q;
		fl_tok.last         = 1'b0;

		// single-byte token at the current position by default
		nw_tok.kind         = punct_kind(char_s1);
		nw_tok.start_line   = LINE_W'(line_q);
		nw_tok.start_column = col_q;
		nw_tok.end_line     = LINE_W'(line_q);
		nw_tok.end_column   = col_q;
		nw_tok.start_offset = OFF_W'(off_q);
		nw_tok.length       = LEN_ONE;
		nw_tok.last         = 1'b0;

		if (in_valid_s1) begin
			if (eot_s1 || char_s1 == CH_NUL) begin
				fl_hit            = pending;
				nw_hit            = 1'b1;
				nw_tok.kind       = KIND_END;
				nw_tok.end_line   = LINE_W'(pl_q);
				nw_tok.end_column = pc_q;
				nw_tok.length     = '0;
				mode_d  = MODE_IDLE;
				count_d = '0;
				line_d  = LINE_ONE;
				col_d   = COL_ONE;
				off_d   = '0;
				tsl_d   = LINE_ONE;
				tsc_d   = COL_ONE;
				tso_d   = '0;
				pl_d    = LINE_ONE;
				pc_d    = COL_ONE;
			end else if (char_s1 == CH_CR) begin
				if (off_q != '1) off_d = off_q + OFF_ONE;
			end else if (mode_q == MODE_ERROR) begin
				nw_hit      = 1'b1;
				nw_tok.kind = KIND_ERROR;
				tsl_d   = line_q;
				tsc_d   = col_q;
				tso_d   = off_q;
				consume = 1'b1;
			end else if (mode_q == MODE_EQ && char_s1 == CH_EQ) begin
				nw_hit              = 1'b1;
				nw_tok.kind         = KIND_EQEQ;
				nw_tok.start_line   = LINE_W'(tsl_q);
				nw_tok.start_column = tsc_q;
				nw_tok.start_offset = OFF_W'(tso_q);
				nw_tok.length       = LEN_W'(2);
				mode_d  = MODE_IDLE;
				consume = 1'b1;
			end else if (mode_q == MODE_IDENT && is_ident_byte(char_s1)) begin
				if (count_q < KPB_CNT) begin
					pfx_we  = 1'b1;
					pfx_idx = count_q[IDX_W-1:0];
				end
				if (count_q != '1) count_d = count_q + LEN_ONE;
				consume = 1'b1;
			end else begin
				// flush what is pending, then treat the byte as if idle
				fl_hit  = pending;
				mode_d  = MODE_IDLE;
				consume = 1'b1;
				if (char_s1 == CH_SPACE || char_s1 == CH_TAB || char_s1 == CH_LF) begin
					mode_d = MODE_IDLE;
				end else if (is_starter(char_s1)) begin
					mode_d  = MODE_IDENT;
					pfx_we  = 1'b1;
					count_d = LEN_ONE;
					tsl_d   = line_q;
					tsc_d   = col_q;
					tso_d   = off_q;
				end else if (char_s1 == CH_EQ) begin
					mode_d = MODE_EQ;
					tsl_d  = line_q;
					tsc_d  = col_q;
					tso_d  = off_q;
				end else begin
					nw_hit = 1'b1;
					tsl_d  = line_q;
					tsc_d  = col_q;
					tso_d  = off_q;
					if (nw_tok.kind == KIND_ERROR) mode_d = MODE_ERROR;
				end
			end
		end

		// advance the position past a consumed byte
		if (consume) begin
			pl_d = line_q;
			pc_d = col_q;
			if (char_s1 == CH_LF) begin
				if (line_q != '1) line_d = line_q + LINE_ONE;
				col_d = COL_ONE;
			end else if (col_q != '1) begin
				col_d = col_q + COL_ONE;
			end
			if (off_q != '1) off_d = off_q + OFF_ONE;
		end

		// order: flushed token first, then the byte's own token
		n_push = {1'b0, fl_hit} + {1'b0, nw_hit};
		t0 = fl_hit ? fl_tok : nw_tok;
		t1 = nw_tok;
		if (n_push == 2'd2) t1.last = 1'b1;
		else t0.last = 1'b1;
	end

	assign pop = tok_valid && !tok_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + QP_W'(n_push);
			rd_q  <= rd_q + QP_W'(pop);
			cnt_q <= cnt_q + QC_W'(n_push) - QC_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) q_mem[wr_q] <= t0;
		if (n_push == 2'd2) q_mem[wr_q + QP_W'(1)] <= t1;
	end

	assign tok_valid    = (cnt_q != '0);
	assign token_kind   = q_mem[rd_q].kind;
	assign start_line   = q_mem[rd_q].start_line;
	assign start_column = q_mem[rd_q].start_column;
	assign end_line     = q_mem[rd_q].end_line;
	assign end_column   = q_mem[rd_q].end_column;
	assign start_offset = q_mem[rd_q].start_offset;
	assign token_length = q_mem[rd_q].length;
	assign last_of_run  = q_mem[rd_q].last;

	`ASSERT_IMP_SAME(a_queue_bound, 1'b1, cnt_q <= QC_W'(Q_DEPTH), "token queue overflow")
	`ASSERT_IMP_NEXT(a_end_resets, is_end_s1, line_q == LINE_ONE && col_q == COL_ONE && off_q == '0, "position not reset after end of text")
	`ASSERT_IMP_NEXT(a_error_sticky, mode_q == MODE_ERROR && !is_end_s1, mode_q == MODE_ERROR, "error mode left before end of text")
	`ASSERT_IMP_SAME(a_end_closes_run, tok_valid && token_kind == KIND_END, last_of_run, "end token without last_of_run")

endmodule
